@@ design/bmm_pkg.sv @@
`default_nettype none
package bmm_pkg;

    // default sizes and fixed alphabet
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int TEXT_DEPTH_DEF    = 4096;
    localparam int ALPHABET_SIZE     = 256;
    localparam int CHAR_W            = $clog2(ALPHABET_SIZE);

    // field widths
    localparam int OPC_W      = 2;
    localparam int ADDR_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int STAT_W     = 3;
    localparam int POS_W      = 12;
    localparam int PLEN_W     = 7;
    localparam int TLEN_W     = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // opcodes
    localparam logic [OPC_W-1:0] OPC_WR_PAT  = 2'd0;
    localparam logic [OPC_W-1:0] OPC_WR_TXT  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_PREPARE = 2'd2;
    localparam logic [OPC_W-1:0] OPC_FIND    = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_MATCH    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_PREPARED = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TXT_LEN = 1'b1;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  match_position;
    } t_rsp;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_WR_PAT,
        OP_WR_TXT,
        OP_REJECT,
        OP_PREP_START,
        OP_BC_FILL,
        OP_BCP_WR,
        OP_GS_INIT,
        OP_L_TOP,
        OP_L_NEXT,
        OP_L_UPD,
        OP_B_CHK,
        OP_B_WR,
        OP_FIND_START,
        OP_S_EQ,
        OP_S_SKIP,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic gs_q;
    } t_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic pat_ok;
        logic txt_ok;
        logic plen_ok;
        logic ready;
        logic c_last;
        logic i_last;
        logic i_zero;
        logic l_cond;
        logic s_end;
        logic s_eq;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ design/bmm_chan_if.sv @@
`default_nettype none
interface bmm_chan_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/bmm_ctrl.sv @@
`default_nettype none
module bmm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_req_valid,
    output logic             o_req_ready,
    input  bmm_pkg::t_sts    i_sts,
    output bmm_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_BC_FILL, S_BCP_RD, S_BCP_WR, S_GS_INIT,
        S_L_TOP, S_L_CMP, S_L_UPD, S_L_RD, S_B_RD, S_B_CHK, S_B_WR,
        S_S_TOP, S_S_CMP, S_S_SKIP, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    // next state and datapath command
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = bmm_pkg::OP_NOP;
        o_cmd.gs_q = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.op = bmm_pkg::OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_FIN;
                o_cmd.op = bmm_pkg::OP_REJECT;
                case (i_sts.opcode)
                    bmm_pkg::OPC_WR_PAT: begin
                        if (i_sts.pat_ok) o_cmd.op = bmm_pkg::OP_WR_PAT;
                    end
                    bmm_pkg::OPC_WR_TXT: begin
                        if (i_sts.txt_ok) o_cmd.op = bmm_pkg::OP_WR_TXT;
                    end
                    bmm_pkg::OPC_PREPARE: begin
                        if (i_sts.plen_ok) begin
                            o_cmd.op = bmm_pkg::OP_PREP_START;
                            n_state  = S_BC_FILL;
                        end
                    end
                    default: begin
                        if (i_sts.ready) begin
                            o_cmd.op = bmm_pkg::OP_FIND_START;
                            n_state  = S_S_TOP;
                        end
                    end
                endcase
            end
            S_BC_FILL: begin
                o_cmd.op = bmm_pkg::OP_BC_FILL;
                if (i_sts.c_last) n_state = S_BCP_RD;
            end
            S_BCP_RD: begin
                n_state = S_BCP_WR;
            end
            S_BCP_WR: begin
                o_cmd.op = bmm_pkg::OP_BCP_WR;
                n_state  = i_sts.i_last ? S_GS_INIT : S_BCP_RD;
            end
            S_GS_INIT: begin
                o_cmd.op = bmm_pkg::OP_GS_INIT;
                if (i_sts.i_last) n_state = S_L_TOP;
            end
            S_L_TOP: begin
                o_cmd.op = bmm_pkg::OP_L_TOP;
                n_state  = S_L_CMP;
            end
            S_L_CMP: begin
                o_cmd.gs_q = 1'b1;
                if (i_sts.l_cond) begin
                    n_state = S_L_UPD;
                end else begin
                    o_cmd.op = bmm_pkg::OP_L_NEXT;
                    n_state  = i_sts.i_zero ? S_B_RD : S_L_TOP;
                end
            end
            S_L_UPD: begin
                o_cmd.op = bmm_pkg::OP_L_UPD;
                n_state  = S_L_RD;
            end
            S_L_RD: begin
                n_state = S_L_CMP;
            end
            S_B_RD: begin
                n_state = S_B_CHK;
            end
            S_B_CHK: begin
                o_cmd.op = bmm_pkg::OP_B_CHK;
                n_state  = S_B_WR;
            end
            S_B_WR: begin
                o_cmd.op = bmm_pkg::OP_B_WR;
                n_state  = i_sts.i_last ? S_FIN : S_B_RD;
            end
            S_S_TOP: begin
                n_state = i_sts.s_end ? S_FIN : S_S_CMP;
            end
            S_S_CMP: begin
                if (i_sts.s_eq) begin
                    o_cmd.op = bmm_pkg::OP_S_EQ;
                    n_state  = i_sts.i_zero ? S_FIN : S_S_TOP;
                end else begin
                    n_state = S_S_SKIP;
                end
            end
            S_S_SKIP: begin
                o_cmd.op = bmm_pkg::OP_S_SKIP;
                n_state  = S_S_TOP;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = bmm_pkg::OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;

endmodule
`default_nettype wire

@@ design/bmm_dp.sv @@
`default_nettype none
module bmm_dp #(
    parameter int PATTERN_DEPTH = bmm_pkg::PATTERN_DEPTH_DEF,
    parameter int TEXT_DEPTH    = bmm_pkg::TEXT_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [bmm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [bmm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  bmm_pkg::t_req                      i_req,
    input  wire                                i_rsp_ready,
    output logic                               o_rsp_valid,
    output bmm_pkg::t_rsp                      o_rsp,
    input  bmm_pkg::t_cmd                      i_cmd,
    output bmm_pkg::t_sts                      o_sts
);

    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int PW  = $clog2(PATTERN_DEPTH + 1);
    localparam int GW  = PW + 1;
    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int LW  = $clog2(TEXT_DEPTH + 1);
    localparam int JW  = $clog2(TEXT_DEPTH + 2 * PATTERN_DEPTH);
    localparam int CW  = bmm_pkg::CHAR_W;

    // stores and tables
    logic [bmm_pkg::BYTE_W-1:0] r_pat_mem [PATTERN_DEPTH];
    logic [bmm_pkg::BYTE_W-1:0] r_txt_mem [TEXT_DEPTH];
    logic [PW-1:0]              r_bc_mem  [bmm_pkg::ALPHABET_SIZE];
    logic [GW-1:0]              r_gs_mem  [PATTERN_DEPTH];
    logic [PW-1:0]              r_fl_mem  [PATTERN_DEPTH];

    logic [bmm_pkg::BYTE_W-1:0] r_pa_rd, r_pb_rd, r_txt_rd;
    logic [PW-1:0]              r_bc_rd, r_fl_rd;
    logic [GW-1:0]              r_gs_rd;

    // configuration and control state
    logic [bmm_pkg::PLEN_W-1:0] r_plen;
    logic [bmm_pkg::TLEN_W-1:0] r_tlen;
    logic [PW-1:0]              r_m, n_m;
    logic                       r_ready, n_ready;
    logic [JW-1:0]              r_j, n_j;
    logic                       r_ov, n_ov;

    // working registers
    logic [bmm_pkg::OPC_W-1:0]  r_op, n_op;
    logic [bmm_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [bmm_pkg::BYTE_W-1:0] r_data, n_data;
    logic [PW-1:0]              r_i, n_i, r_q, n_q;
    logic [CW-1:0]              r_c, n_c;
    logic [bmm_pkg::STAT_W-1:0] r_st, n_st, r_ostat, n_ostat;
    logic [bmm_pkg::POS_W-1:0]  r_pos, n_pos, r_opos, n_opos;

    // memory write controls
    logic                       pat_we, txt_we, bc_we, gs_we, fl_we;
    logic [CW-1:0]              bc_wa;
    logic [PW-1:0]              bc_wd;
    logic [PAW-1:0]             gs_wa, gs_ra;
    logic [GW-1:0]              gs_wd, gs_cand, skip;
    logic [LW-1:0]              len;
    logic                       i_last, i_zero;

    assign i_last = (r_i == r_m - PW'(1));
    assign i_zero = (r_i == '0);
    assign len    = (32'(r_tlen) < 32'(TEXT_DEPTH)) ? LW'(r_tlen) : LW'(TEXT_DEPTH);
    assign gs_ra  = i_cmd.gs_q ? r_q[PAW-1:0] : r_i[PAW-1:0];
    assign skip   = (GW'(r_bc_rd) > r_gs_rd) ? GW'(r_bc_rd) : r_gs_rd;

    // status toward the controller
    always_comb begin
        o_sts.opcode   = r_op;
        o_sts.pat_ok   = 32'(r_addr) < 32'(PATTERN_DEPTH);
        o_sts.txt_ok   = 32'(r_addr) < 32'(TEXT_DEPTH);
        o_sts.plen_ok  = (r_plen != '0) && (32'(r_plen) <= 32'(PATTERN_DEPTH));
        o_sts.ready    = r_ready;
        o_sts.c_last   = (r_c == CW'(bmm_pkg::ALPHABET_SIZE - 1));
        o_sts.i_last   = i_last;
        o_sts.i_zero   = i_zero;
        o_sts.l_cond   = (r_q < r_m) && (r_pa_rd != r_pb_rd);
        o_sts.s_end    = 32'(r_j) >= 32'(len);
        o_sts.s_eq     = (r_txt_rd == r_pa_rd);
        o_sts.out_free = !r_ov || i_rsp_ready;
    end

    // micro-operation execution
    always_comb begin
        n_m     = r_m;
        n_ready = r_ready;
        n_j     = r_j;
        n_ov    = r_ov;
        n_op    = r_op;
        n_addr  = r_addr;
        n_data  = r_data;
        n_i     = r_i;
        n_q     = r_q;
        n_c     = r_c;
        n_st    = r_st;
        n_pos   = r_pos;
        n_ostat = r_ostat;
        n_opos  = r_opos;
        pat_we  = 1'b0;
        txt_we  = 1'b0;
        bc_we   = 1'b0;
        gs_we   = 1'b0;
        fl_we   = 1'b0;
        bc_wa   = r_c;
        bc_wd   = r_m;
        gs_wa   = r_i[PAW-1:0];
        gs_wd   = '0;
        gs_cand = '0;
        if (r_ov && i_rsp_ready) n_ov = 1'b0;
        case (i_cmd.op)
            bmm_pkg::OP_LOAD: begin
                n_op   = i_req.opcode;
                n_addr = i_req.address;
                n_data = i_req.data_byte;
                n_pos  = '0;
            end
            bmm_pkg::OP_WR_PAT: begin
                pat_we  = 1'b1;
                n_ready = 1'b0;
                n_st    = bmm_pkg::ST_STORED;
            end
            bmm_pkg::OP_WR_TXT: begin
                txt_we = 1'b1;
                n_st   = bmm_pkg::ST_STORED;
            end
            bmm_pkg::OP_REJECT: begin
                n_st = bmm_pkg::ST_REJECTED;
            end
            bmm_pkg::OP_PREP_START: begin
                n_m = PW'(r_plen);
                n_c = '0;
                n_i = '0;
            end
            bmm_pkg::OP_BC_FILL: begin
                bc_we = 1'b1;
                n_c   = r_c + CW'(1);
            end
            bmm_pkg::OP_BCP_WR: begin
                bc_we = 1'b1;
                bc_wa = CW'(r_pa_rd);
                bc_wd = r_m - PW'(1) - r_i;
                n_i   = i_last ? '0 : r_i + PW'(1);
            end
            bmm_pkg::OP_GS_INIT: begin
                gs_we = 1'b1;
                gs_wd = GW'({r_m, 1'b0}) - GW'(1) - GW'(r_i);
                if (i_last) begin
                    n_i = r_m - PW'(1);
                    n_q = r_m;
                end else begin
                    n_i = r_i + PW'(1);
                end
            end
            bmm_pkg::OP_L_TOP: begin
                fl_we = 1'b1;
            end
            bmm_pkg::OP_L_NEXT: begin
                // the border walk keeps q as one past the widest border
                if (!i_zero) begin
                    n_q = r_q - PW'(1);
                    n_i = r_i - PW'(1);
                end
            end
            bmm_pkg::OP_L_UPD: begin
                gs_we   = 1'b1;
                gs_wa   = r_q[PAW-1:0];
                gs_cand = GW'(r_m) - GW'(1) - GW'(r_i);
                gs_wd   = (gs_cand < r_gs_rd) ? gs_cand : r_gs_rd;
                n_q     = r_fl_rd;
            end
            bmm_pkg::OP_B_CHK: begin
                if (r_i >= r_q) n_q = r_fl_rd;
            end
            bmm_pkg::OP_B_WR: begin
                gs_we   = 1'b1;
                gs_cand = GW'(r_m) + GW'(r_q) - GW'(1) - GW'(r_i);
                gs_wd   = (gs_cand < r_gs_rd) ? gs_cand : r_gs_rd;
                if (i_last) begin
                    n_j     = JW'(r_m) - JW'(1);
                    n_ready = 1'b1;
                    n_st    = bmm_pkg::ST_PREPARED;
                end else begin
                    n_i = r_i + PW'(1);
                end
            end
            bmm_pkg::OP_FIND_START: begin
                n_i  = r_m - PW'(1);
                n_st = bmm_pkg::ST_NONE;
            end
            bmm_pkg::OP_S_EQ: begin
                if (i_zero) begin
                    n_st  = bmm_pkg::ST_MATCH;
                    n_pos = bmm_pkg::POS_W'(r_j);
                    n_j   = r_j + JW'(r_m);
                end else begin
                    n_i = r_i - PW'(1);
                    n_j = r_j - JW'(1);
                end
            end
            bmm_pkg::OP_S_SKIP: begin
                n_j = r_j + JW'(skip);
                n_i = r_m - PW'(1);
            end
            bmm_pkg::OP_PUSH: begin
                n_ov    = 1'b1;
                n_ostat = r_st;
                n_opos  = r_pos;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= bmm_pkg::PLEN_W'(1);
            r_tlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmm_pkg::CFG_PAT_LEN: r_plen <= bmm_pkg::PLEN_W'(i_cfg_data);
                bmm_pkg::CFG_TXT_LEN: r_tlen <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m     <= PW'(1);
            r_ready <= 1'b0;
            r_j     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_m     <= n_m;
            r_ready <= n_ready;
            r_j     <= n_j;
            r_ov    <= n_ov;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_addr  <= n_addr;
        r_data  <= n_data;
        r_i     <= n_i;
        r_q     <= n_q;
        r_c     <= n_c;
        r_st    <= n_st;
        r_pos   <= n_pos;
        r_ostat <= n_ostat;
        r_opos  <= n_opos;
    end

    // pattern store, two read ports
    always_ff @(posedge i_clk) begin
        if (pat_we) r_pat_mem[r_addr[PAW-1:0]] <= r_data;
        r_pa_rd <= r_pat_mem[r_i[PAW-1:0]];
        r_pb_rd <= r_pat_mem[r_q[PAW-1:0]];
    end

    // text store
    always_ff @(posedge i_clk) begin
        if (txt_we) r_txt_mem[TAW'(r_addr)] <= r_data;
        r_txt_rd <= r_txt_mem[r_j[TAW-1:0]];
    end

    // bad-character table, indexed by the text byte just read
    always_ff @(posedge i_clk) begin
        if (bc_we) r_bc_mem[bc_wa] <= bc_wd;
        r_bc_rd <= r_bc_mem[r_txt_rd];
    end

    // good-suffix table
    always_ff @(posedge i_clk) begin
        if (gs_we) r_gs_mem[gs_wa] <= gs_wd;
        r_gs_rd <= r_gs_mem[gs_ra];
    end

    // failure links
    always_ff @(posedge i_clk) begin
        if (fl_we) r_fl_mem[r_i[PAW-1:0]] <= r_q;
        r_fl_rd <= r_fl_mem[r_q[PAW-1:0]];
    end

    assign o_rsp_valid          = r_ov;
    assign o_rsp.status         = r_ostat;
    assign o_rsp.match_position = r_opos;

endmodule
`default_nettype wire

@@ design/boyer_moore_matcher.sv @@
`default_nettype none
// Boyer-Moore exact string search over a pattern store and a text store that are loaded
// byte by byte. Each input item gives exactly one result item, and a new request is
// accepted only after the previous result has entered the output register. A prepare
// runs the 256-entry sweep that fills the bad-character table, one entry per cycle,
// then passes over the pattern bytes for the bad-character and good-suffix tables, the
// failure-link walk and a final good-suffix pass. In a find, each compare waits on a
// registered read of the text and pattern stores and each skip on reads of the
// bad-character and good-suffix tables. Matches may overlap; the search window persists
// between finds, and a finished result waits in an output register until taken.
module boyer_moore_matcher #(
    parameter int PATTERN_DEPTH = bmm_pkg::PATTERN_DEPTH_DEF,
    parameter int TEXT_DEPTH    = bmm_pkg::TEXT_DEPTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [bmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [bmm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bmm_chan_if.sink                        i_req,
    bmm_chan_if.source                      o_rsp
);

    bmm_pkg::t_cmd cmd;
    bmm_pkg::t_sts sts;
    bmm_pkg::t_req req_payload;
    bmm_pkg::t_rsp rsp_payload;

    assign req_payload   = i_req.payload;
    assign o_rsp.payload = rsp_payload;

    // sequencer
    bmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, tables and search registers
    bmm_dp #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TEXT_DEPTH    (TEXT_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_payload),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp       (rsp_payload),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
